/* sv/dsi_pkg.sv */
package dsi_pkg;

   // Field widths of one word on either channel
   localparam int SecW   = 17;
   localparam int PwrW   = 7;
   localparam int CtW    = 16;
   localparam int IdxW   = 4;
   localparam int CountW = 5;

   // Packed channel widths, rounded up to whole bytes
   localparam int ReqDataW = 64;
   localparam int RspDataW = 24;

   // Schedule table defaults
   localparam int MaxPointsDefault = 16;
   localparam logic [CountW-1:0] PointCountReset = CountW'(1);

   // Saturation limits of the interpolated outputs
   localparam int PowerMax = 100;
   localparam int CtMax    = 65535;

   // Product width of color delta times time offset, also the divider width
   localparam int DivW = 35;

   // Depth of the queue between front and back
   localparam int QueueDepth = 2;

   // Command codes on the request channel
   localparam logic CmdWrite = 1'b0;
   localparam logic CmdQuery = 1'b1;

   // Operation kinds in the queue
   localparam logic OpWrite = 1'b0;
   localparam logic OpQuery = 1'b1;

   // One schedule point as stored in the table
   typedef struct packed {
      logic [SecW-1:0] seconds;
      logic [PwrW-1:0] power;
      logic [CtW-1:0]  kelvin;
   } entry_type;

   // One classified operation; seconds carries the current time for a query
   typedef struct packed {
      logic            kind;
      logic [IdxW-1:0] index;
      logic [SecW-1:0] seconds;
      logic [PwrW-1:0] power;
      logic [CtW-1:0]  kelvin;
   } op_type;

endpackage

/* sv/dsi_ram.sv */
module dsi_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dsi_div.sv */
module dsi_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [dsi_pkg::SecW-1:0]   divisor,
   input  logic [dsi_pkg::DivW-1:0]   num_a,
   input  logic [dsi_pkg::DivW-1:0]   num_b,
   output logic                       done,
   output logic [dsi_pkg::DivW-1:0]   quo_a,
   output logic [dsi_pkg::DivW-1:0]   quo_b
);

   localparam int SecW = dsi_pkg::SecW;
   localparam int DivW = dsi_pkg::DivW;
   localparam int CntW = $clog2(DivW + 1);

   logic [SecW-1:0] den_ff;
   logic [SecW-1:0] rem_ff [2];
   logic [SecW-1:0] rem_in [2];
   logic [DivW-1:0] quo_ff [2];
   logic [DivW-1:0] quo_in [2];
   logic [SecW:0]   rem_sh [2];
   logic            ge     [2];
   logic [CntW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   // One restoring step per lane: shift in a numerator bit, subtract if it fits
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rem_sh[l] = {rem_ff[l], quo_ff[l][DivW-1]};
         ge[l]     = rem_sh[l] >= {1'b0, den_ff};
         rem_in[l] = ge[l] ? SecW'(rem_sh[l] - {1'b0, den_ff}) : SecW'(rem_sh[l]);
         quo_in[l] = {quo_ff[l][DivW-2:0], ge[l]};
      end
   end

   // Load numerators on start, then step once per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff    <= divisor;
         quo_ff[0] <= num_a;
         quo_ff[1] <= num_b;
         rem_ff[0] <= '0;
         rem_ff[1] <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Count the steps and flag the final quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(DivW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done  = done_ff;
   assign quo_a = quo_ff[0];
   assign quo_b = quo_ff[1];

endmodule

/* sv/dsi_front.sv */
module dsi_front #(
   parameter int MaxPoints = dsi_pkg::MaxPointsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [dsi_pkg::ReqDataW-1:0] req_tdata,
   input  logic                         req_tuser,
   output logic                         op_valid,
   output dsi_pkg::op_type              op,
   input  logic                         op_pop
);

   localparam int Depth = dsi_pkg::QueueDepth;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   dsi_pkg::op_type  queue_ff [Depth];
   dsi_pkg::op_type  op_in;
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [CntW-1:0]  count_ff;
   logic             is_query;
   logic             keep;
   logic             push;

   // Classify the word: a query carries the current time, a write a point
   always_comb begin
      is_query         = req_tuser == dsi_pkg::CmdQuery;
      op_in.kind       = is_query ? dsi_pkg::OpQuery : dsi_pkg::OpWrite;
      op_in.index      = req_tdata[3:0];
      op_in.seconds    = is_query ? req_tdata[60:44] : req_tdata[20:4];
      op_in.power      = req_tdata[27:21];
      op_in.kelvin     = req_tdata[43:28];
      // drop writes beyond the table
      keep             = is_query || (32'(op_in.index) < MaxPoints);
   end

   assign req_tready = count_ff != CntW'(Depth);
   assign push       = req_tvalid && req_tready && keep;
   assign op_valid   = count_ff != '0;
   assign op         = queue_ff[rd_ptr_ff];

   // Hold queued operations
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= op_in;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (op_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !op_pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (op_pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      op_pop |-> count_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

/* sv/dsi_back.sv */
module dsi_back #(
   parameter int MaxPoints = dsi_pkg::MaxPointsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         op_valid,
   input  dsi_pkg::op_type              op,
   output logic                         op_pop,
   input  logic [dsi_pkg::CountW-1:0]   point_count,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [dsi_pkg::RspDataW-1:0] rsp_tdata,
   output logic                         rsp_tuser
);

   localparam int SecW = dsi_pkg::SecW;
   localparam int PwrW = dsi_pkg::PwrW;
   localparam int CtW  = dsi_pkg::CtW;
   localparam int DivW = dsi_pkg::DivW;
   localparam int AW   = $clog2(MaxPoints);
   localparam int CntW = $clog2(MaxPoints + 1);
   localparam int EntW = $bits(dsi_pkg::entry_type);
   localparam int PwNumW = (PwrW + 1) + (SecW + 1);
   localparam int CtNumW = (CtW + 1) + (SecW + 1);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StScan = 3'd1;
   localparam logic [2:0] StMult = 3'd2;
   localparam logic [2:0] StDivS = 3'd3;
   localparam logic [2:0] StDivW = 3'd4;
   localparam logic [2:0] StFix  = 3'd5;
   localparam logic [2:0] StOut  = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [CntW-1:0]         n_act;
   logic [CntW-1:0]         issue_ff;
   logic                    more;
   logic                    rd_pend_ff;
   logic                    rd_first_ff;
   logic [SecW-1:0]         now_ff;
   logic                    ram_we;
   logic [EntW-1:0]         ram_rd_data;
   dsi_pkg::entry_type      ram_wr_entry;
   dsi_pkg::entry_type      entry;
   logic                    is_prev;
   logic [SecW-1:0]         gap;
   dsi_pkg::entry_type      prev_ff, succ_ff;
   logic                    prev_hit_ff, succ_hit_ff;
   logic [SecW-1:0]         prev_d_ff, succ_d_ff;
   dsi_pkg::entry_type      lo, hi;
   logic signed [PwrW:0]    d_pw;
   logic signed [CtW:0]     d_ct;
   logic signed [SecW:0]    d_now;
   logic signed [PwNumW-1:0] pw_num_ff;
   logic signed [CtNumW-1:0] ct_num_ff;
   logic [SecW-1:0]         span_ff;
   logic [PwrW-1:0]         base_pw_ff;
   logic [CtW-1:0]          base_ct_ff;
   logic                    degen_ff;
   logic                    pw_neg, ct_neg;
   logic [PwNumW-1:0]       pw_abs;
   logic [CtNumW-1:0]       ct_abs;
   logic                    div_start;
   logic                    div_done;
   logic [DivW-1:0]         quo_a, quo_b;
   logic signed [DivW:0]    sq_pw, sq_ct;
   logic signed [DivW+1:0]  sum_pw, sum_ct;
   logic [PwrW-1:0]         res_pw_ff, sat_pw;
   logic [CtW-1:0]          res_ct_ff, sat_ct;
   logic                    res_degen_ff;
   logic                    rsp_valid_ff;
   logic [PwrW-1:0]         out_pw_ff;
   logic [CtW-1:0]          out_ct_ff;
   logic                    out_degen_ff;
   logic                    out_load;

   // Active entry count: zero acts as one, clip to table size
   always_comb begin
      if (point_count == '0) begin
         n_act = CntW'(1);
      end else if (32'(point_count) > MaxPoints) begin
         n_act = CntW'(MaxPoints);
      end else begin
         n_act = CntW'(point_count);
      end
   end

   assign op_pop = (state_ff == StIdle) && op_valid;
   assign ram_we = op_pop && (op.kind == dsi_pkg::OpWrite);
   assign more   = issue_ff < n_act;

   always_comb begin
      ram_wr_entry.seconds = op.seconds;
      ram_wr_entry.power   = op.power;
      ram_wr_entry.kelvin  = op.kelvin;
   end

   dsi_ram #(
      .Width (EntW),
      .Depth (MaxPoints)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(op.index)),
      .wr_data (ram_wr_entry),
      .rd_addr (AW'(issue_ff)),
      .rd_data (ram_rd_data)
   );

   // Classify the entry just read against the current time
   always_comb begin
      entry   = dsi_pkg::entry_type'(ram_rd_data);
      is_prev = entry.seconds <= now_ff;
      gap     = is_prev ? now_ff - entry.seconds : entry.seconds - now_ff;
   end

   // Order the chosen pair and form the interpolation products' operands
   always_comb begin
      if (succ_ff.seconds < prev_ff.seconds) begin
         lo = succ_ff;
         hi = prev_ff;
      end else begin
         lo = prev_ff;
         hi = succ_ff;
      end
      d_pw  = $signed({1'b0, hi.power}) - $signed({1'b0, lo.power});
      d_ct  = $signed({1'b0, hi.kelvin}) - $signed({1'b0, lo.kelvin});
      d_now = $signed({1'b0, now_ff}) - $signed({1'b0, lo.seconds});
   end

   // Magnitudes into the divider, signs kept aside
   always_comb begin
      pw_neg = pw_num_ff[PwNumW-1];
      ct_neg = ct_num_ff[CtNumW-1];
      pw_abs = pw_neg ? PwNumW'(-pw_num_ff) : PwNumW'(pw_num_ff);
      ct_abs = ct_neg ? CtNumW'(-ct_num_ff) : CtNumW'(ct_num_ff);
   end

   assign div_start = state_ff == StDivS;

   dsi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (span_ff),
      .num_a   (DivW'(pw_abs)),
      .num_b   (DivW'(ct_abs)),
      .done    (div_done),
      .quo_a   (quo_a),
      .quo_b   (quo_b)
   );

   // Restore signs, add the base point, saturate
   always_comb begin
      sq_pw  = pw_neg ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
      sq_ct  = ct_neg ? -$signed({1'b0, quo_b}) : $signed({1'b0, quo_b});
      sum_pw = $signed({sq_pw[DivW], sq_pw})
             + $signed({{(DivW + 2 - PwrW){1'b0}}, base_pw_ff});
      sum_ct = $signed({sq_ct[DivW], sq_ct})
             + $signed({{(DivW + 2 - CtW){1'b0}}, base_ct_ff});
      if (sum_pw[DivW+1]) begin
         sat_pw = '0;
      end else if (sum_pw > (DivW + 2)'(dsi_pkg::PowerMax)) begin
         sat_pw = PwrW'(dsi_pkg::PowerMax);
      end else begin
         sat_pw = sum_pw[PwrW-1:0];
      end
      if (sum_ct[DivW+1]) begin
         sat_ct = '0;
      end else if (sum_ct > (DivW + 2)'(dsi_pkg::CtMax)) begin
         sat_ct = CtW'(dsi_pkg::CtMax);
      end else begin
         sat_ct = sum_ct[CtW-1:0];
      end
   end

   assign out_load = (state_ff == StOut) && (!rsp_valid_ff || rsp_tready);

   // Sequence one operation at a time
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (op_pop && (op.kind == dsi_pkg::OpQuery)) begin
               state_in = StScan;
            end
         end
         StScan: begin
            if (!more && !rd_pend_ff) begin
               state_in = StMult;
            end
         end
         StMult: state_in = (hi.seconds == lo.seconds) ? StFix : StDivS;
         StDivS: state_in = StDivW;
         StDivW: begin
            if (div_done) begin
               state_in = StFix;
            end
         end
         StFix: state_in = StOut;
         StOut: begin
            if (out_load) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rd_pend_ff   <= 1'b0;
         rd_first_ff  <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (op_pop) begin
            issue_ff <= '0;
         end else if ((state_ff == StScan) && more) begin
            issue_ff <= issue_ff + CntW'(1);
         end
         rd_pend_ff  <= (state_ff == StScan) && more;
         rd_first_ff <= (state_ff == StScan) && more && (issue_ff == '0);
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan: entry zero seeds both picks, later entries replace on a strictly closer hit
   always_ff @(posedge clock) begin
      if (op_pop) begin
         now_ff <= op.seconds;
      end
      if (rd_pend_ff) begin
         if (rd_first_ff || (is_prev && (!prev_hit_ff || gap < prev_d_ff))) begin
            prev_ff     <= entry;
            prev_hit_ff <= is_prev;
            prev_d_ff   <= gap;
         end
         if (rd_first_ff || (!is_prev && (!succ_hit_ff || gap < succ_d_ff))) begin
            succ_ff     <= entry;
            succ_hit_ff <= !is_prev;
            succ_d_ff   <= gap;
         end
      end
   end

   // Register products, span and base point
   always_ff @(posedge clock) begin
      if (state_ff == StMult) begin
         pw_num_ff  <= d_pw * d_now;
         ct_num_ff  <= d_ct * d_now;
         span_ff    <= hi.seconds - lo.seconds;
         base_pw_ff <= lo.power;
         base_ct_ff <= lo.kelvin;
         degen_ff   <= hi.seconds == lo.seconds;
      end
   end

   // Hold the finished result, zero when the pair shares a time
   always_ff @(posedge clock) begin
      if (state_ff == StFix) begin
         res_pw_ff    <= degen_ff ? '0 : sat_pw;
         res_ct_ff    <= degen_ff ? '0 : sat_ct;
         res_degen_ff <= degen_ff;
      end
      if (out_load) begin
         out_pw_ff    <= res_pw_ff;
         out_ct_ff    <= res_ct_ff;
         out_degen_ff <= res_degen_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dsi_pkg::RspDataW - PwrW - CtW){1'b0}}, out_ct_ff, out_pw_ff};
   assign rsp_tuser  = out_degen_ff;

`ifndef SYNTHESIS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_degen_ff |-> out_pw_ff == '0 && out_ct_ff == '0)
      else $error("degenerate word with nonzero outputs");

   a_power_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> out_pw_ff <= PwrW'(dsi_pkg::PowerMax))
      else $error("power output not saturated");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == StDivW)
      else $error("divider finished outside wait state");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == StScan |-> issue_ff <= n_act)
      else $error("scan address past active count");

   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == StOut)
      else $error("result raised outside output state");
`endif

endmodule

/* sv/daily_schedule_interpolator_core.sv */
// Daily schedule interpolator. Write words (tuser command 0) load one point of
// a table of up to MaxPoints entries (time of day, power percent, color
// temperature) and produce no result; query words (tuser command 1) return
// power and color temperature interpolated between the nearest point at or
// before now and the nearest point after it, saturated, with a degenerate flag
// when both points share a time. csr_wr_data sets how many entries a query
// scans. A front stage classifies words into a two-deep queue; the back stage
// runs them in order. A write is stored in the table as it is taken from the
// queue. A query is taken from the queue, scans the active entries through the
// table memory's single registered read port, multiplies, then starts the
// bit-serial divider, runs its 35 steps for both quotients side by side and
// sees it finish (skipped when both points share a time), saturates and hands
// over. A stalled result receiver adds its stall to the hand-over. The result
// register lets the next word start while a result waits to be taken.
module daily_schedule_interpolator_core #(
   parameter int MaxPoints = dsi_pkg::MaxPointsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // tdata: point_index[3:0], point_seconds[20:4], point_power[27:21],
   //        point_kelvin[43:28], now_seconds[60:44], zeros[63:61]
   input  logic [dsi_pkg::ReqDataW-1:0] req_tdata,
   // tuser: command (0 write point, 1 query)
   input  logic                         req_tuser,
   // response channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // tdata: power_out[6:0], kelvin_out[22:7], zero[23]
   output logic [dsi_pkg::RspDataW-1:0] rsp_tdata,
   // tuser: degenerate
   output logic                         rsp_tuser,
   // point count register
   input  logic                         csr_wr_en,
   input  logic [dsi_pkg::CountW-1:0]   csr_wr_data
);

   logic [dsi_pkg::CountW-1:0] point_count_ff;
   logic                       op_valid;
   logic                       op_pop;
   dsi_pkg::op_type            op;

   // Hold the point count register
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= dsi_pkg::PointCountReset;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   dsi_front #(
      .MaxPoints (MaxPoints)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (op_valid),
      .op         (op),
      .op_pop     (op_pop)
   );

   dsi_back #(
      .MaxPoints (MaxPoints)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (op_valid),
      .op          (op),
      .op_pop      (op_pop),
      .point_count (point_count_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* test/daily_schedule_interpolator_core_tb.sv */
`timescale 1ns / 100ps

module daily_schedule_interpolator_core_tb;

   localparam int ClockPeriod = 20;
   localparam int ResetCycles = 7;
   localparam int DrainCycles = 120;
   localparam int LongHold    = 400;
   localparam int NumPoints   = dsi_pkg::MaxPointsDefault;
   localparam int SecW        = dsi_pkg::SecW;
   localparam int PwrW        = dsi_pkg::PwrW;
   localparam int CtW         = dsi_pkg::CtW;
   localparam int IdxW        = dsi_pkg::IdxW;
   localparam int CountW      = dsi_pkg::CountW;
   localparam int ReqDataW    = dsi_pkg::ReqDataW;
   localparam int RspDataW    = dsi_pkg::RspDataW;
   localparam int PowerMax    = dsi_pkg::PowerMax;
   localparam int CtMax       = dsi_pkg::CtMax;

   typedef enum int {
      TRAFFIC_STEADY,
      TRAFFIC_SENDER_IDLE,
      TRAFFIC_RECEIVER_STALL,
      TRAFFIC_BOTH_IDLE
   } traffic_mode_type;

   // One request word before packing
   typedef struct {
      logic            cmd;
      logic [IdxW-1:0] idx;
      logic [SecW-1:0] sec;
      logic [PwrW-1:0] pwr;
      logic [CtW-1:0]  ct;
      logic [SecW-1:0] now;
   } req_word_type;

   // One interpolated setting as returned on the response channel
   typedef struct {
      logic [PwrW-1:0] power;
      logic [CtW-1:0]  kelvin;
      logic            degenerate;
   } setting_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                csr_wr_en = 1'b0;
   logic [CountW-1:0]   csr_wr_data = '0;

   // Shadow copy of the schedule and the point count
   dsi_pkg::entry_type sched_tbl [NumPoints];
   logic [CountW-1:0]  scan_count = dsi_pkg::PointCountReset;

   req_word_type     pending_words [$];
   setting_type      expected_settings [$];
   traffic_mode_type traffic_mode = TRAFFIC_STEADY;
   logic             req_fire = 1'b0;
   int               hold_requests = 0;
   int               hold_served = 0;
   int               hold_left = 0;
   int               mismatches = 0;
   int               n_writes = 0;
   int               n_queries = 0;
   int               n_results = 0;
   int               n_degenerate = 0;

   daily_schedule_interpolator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Pick the bracketing points and interpolate between them
   function automatic setting_type predict_setting(logic [SecW-1:0] now);
      int                 n;
      int                 prev_i;
      int                 next_i;
      longint             prev_d;
      longint             next_d;
      longint             diff;
      longint             sec_l;
      longint             now_l;
      longint             span;
      longint             pw;
      longint             ct;
      dsi_pkg::entry_type p;
      dsi_pkg::entry_type q;
      dsi_pkg::entry_type t;
      setting_type        r;
      n = (scan_count == '0) ? 1
        : (int'(scan_count) > NumPoints) ? NumPoints : int'(scan_count);
      prev_i = 0;
      next_i = 0;
      prev_d = 64'sd2147483647;
      next_d = 64'sd2147483647;
      now_l = now;
      for (int i = 0; i < n; i++) begin
         sec_l = sched_tbl[IdxW'(i)].seconds;
         diff = sec_l - now_l;
         if (diff <= 0 && -diff < prev_d) begin
            prev_d = -diff;
            prev_i = i;
         end
         if (diff > 0 && diff < next_d) begin
            next_d = diff;
            next_i = i;
         end
      end
      p = sched_tbl[IdxW'(prev_i)];
      q = sched_tbl[IdxW'(next_i)];
      if (q.seconds < p.seconds) begin
         t = p;
         p = q;
         q = t;
      end
      if (q.seconds == p.seconds) begin
         r.power = '0;
         r.kelvin = '0;
         r.degenerate = 1'b1;
         return r;
      end
      span = longint'(q.seconds) - longint'(p.seconds);
      pw = (longint'(q.power) - longint'(p.power)) * (now_l - longint'(p.seconds)) / span
           + longint'(p.power);
      ct = (longint'(q.kelvin) - longint'(p.kelvin)) * (now_l - longint'(p.seconds))
           / span + longint'(p.kelvin);
      if (pw < 0) pw = 0;
      if (pw > PowerMax) pw = PowerMax;
      if (ct < 0) ct = 0;
      if (ct > CtMax) ct = CtMax;
      r.power = pw[PwrW-1:0];
      r.kelvin = ct[CtW-1:0];
      r.degenerate = 1'b0;
      return r;
   endfunction

   function automatic logic [ReqDataW-1:0] pack_word(req_word_type w);
      return {3'b000, w.now, w.ct, w.pwr, w.sec, w.idx};
   endfunction

   function automatic logic sender_idles();
      case (traffic_mode)
         TRAFFIC_SENDER_IDLE: return $urandom_range(99) < 70;
         TRAFFIC_BOTH_IDLE:   return $urandom_range(99) < 10;
         default:             return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (traffic_mode)
         TRAFFIC_RECEIVER_STALL: return $urandom_range(99) < 70;
         TRAFFIC_BOTH_IDLE:      return $urandom_range(99) < 10;
         default:                return 1'b0;
      endcase
   endfunction

   // Random word: mostly in-range times and powers, some hits on stored times
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      w.cmd = ($urandom_range(99) < 55) ? dsi_pkg::CmdQuery : dsi_pkg::CmdWrite;
      w.idx = IdxW'($urandom_range(NumPoints - 1));
      pick = $urandom_range(99);
      if (pick < 80)
         w.sec = SecW'($urandom_range(86399));
      else if (pick < 92)
         w.sec = sched_tbl[IdxW'($urandom_range(NumPoints - 1))].seconds;
      else
         w.sec = SecW'($urandom_range(131071));
      w.pwr = ($urandom_range(99) < 85) ? PwrW'($urandom_range(PowerMax))
                                        : PwrW'($urandom_range(127));
      w.ct = CtW'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 60)
         w.now = SecW'($urandom_range(86399));
      else if (pick < 85)
         w.now = SecW'(sched_tbl[IdxW'($urandom_range(NumPoints - 1))].seconds
                       + $urandom_range(2) - 1);
      else
         w.now = SecW'($urandom_range(131071));
      return w;
   endfunction

   task automatic push_word(logic cmd, int idx, int sec, int pwr, int ct, int now);
      req_word_type w;
      w.cmd = cmd;
      w.idx = IdxW'(idx);
      w.sec = SecW'(sec);
      w.pwr = PwrW'(pwr);
      w.ct = CtW'(ct);
      w.now = SecW'(now);
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic log_mismatch(string what);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // Apply an accepted request word to the shadow table, or predict its setting
   task automatic accept_word(logic cmd, logic [ReqDataW-1:0] d);
      setting_type s;
      if (cmd == dsi_pkg::CmdWrite) begin
         sched_tbl[d[3:0]].seconds = d[20:4];
         sched_tbl[d[3:0]].power = d[27:21];
         sched_tbl[d[3:0]].kelvin = d[43:28];
         n_writes++;
      end else begin
         s = predict_setting(d[60:44]);
         expected_settings.insert(expected_settings.size(), s);
         n_queries++;
         if (s.degenerate) n_degenerate++;
      end
   endtask

   // Compare one response word with the oldest predicted setting
   task automatic check_setting();
      setting_type s;
      n_results++;
      if (expected_settings.size() == 0) begin
         log_mismatch($sformatf("unexpected result tdata=%h tuser=%b", rsp_tdata, rsp_tuser));
      end else begin
         s = expected_settings.pop_front();
         if (rsp_tdata[6:0] !== s.power || rsp_tdata[22:7] !== s.kelvin
             || rsp_tuser !== s.degenerate)
            log_mismatch($sformatf("power %0d/%0d color %0d/%0d degenerate %b/%b (exp/act)",
               s.power, rsp_tdata[6:0], s.kelvin, rsp_tdata[22:7],
               s.degenerate, rsp_tuser));
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_setting();
         if (req_tvalid && req_tready) accept_word(req_tuser, req_tdata);
      end
   end

   // Drive request words at the falling edge; advance only after a handshake
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_words.size() > 0 && !sender_idles()) begin
            req_tdata <= pack_word(pending_words[0]);
            req_tuser <= pending_words[0].cmd;
            req_tvalid <= 1'b1;
            pending_words.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Drive the response ready; hold it low for a long stretch on request
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left = LongHold;
         hold_served = hold_requests;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_stalls();
      end
   end

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_tvalid || expected_settings.size() != 0)
         @(posedge clock);
   endtask

   // Let trailing writes finish, then load the point count
   task automatic set_count(int value);
      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CountW'(value);
      scan_count = CountW'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(int count, traffic_mode_type mode, int items, bit hold, bit pause);
      set_count(count);
      traffic_mode = mode;
      if (hold) hold_requests++;
      for (int i = 0; i < items; i++) begin
         if (pause && i == items / 2) wait_idle();
         pending_words.insert(pending_words.size(), random_word());
      end
   endtask

   initial begin
      for (int i = 0; i < NumPoints; i++) sched_tbl[IdxW'(i)] = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single point in use: every query sees one point twice
      push_word(dsi_pkg::CmdWrite, 0, 0, 0, 0, 131071);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 0);
      push_word(dsi_pkg::CmdQuery, 15, 131071, 127, 65535, 131071);
      push_word(dsi_pkg::CmdWrite, 0, 86399, PowerMax, CtMax, 0);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 86399);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 0);

      // Fill the rest of the table; entries 6 and 7 share a time, 15 sits past midnight
      for (int i = 1; i < NumPoints; i++)
         push_word(dsi_pkg::CmdWrite, i, (i == 15) ? 131071 : (i == 7) ? 6 * 5400 : i * 5400,
                   (i * 37) % 128, i * 4369, 0);

      // Full table: exact hit, just before, below all points, ties, past the end
      set_count(NumPoints);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 5400);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 5399);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 0);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 32400);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 100000);
      push_word(dsi_pkg::CmdQuery, 0, 0, 0, 0, 131071);

      run_phase(NumPoints, TRAFFIC_STEADY, 60, 1'b1, 1'b0);
      run_phase(31, TRAFFIC_SENDER_IDLE, 60, 1'b0, 1'b0);
      run_phase(0, TRAFFIC_RECEIVER_STALL, 50, 1'b0, 1'b0);
      run_phase(5, TRAFFIC_BOTH_IDLE, 60, 1'b0, 1'b0);
      run_phase(NumPoints, TRAFFIC_STEADY, 60, 1'b0, 1'b1);
      run_phase($urandom_range(31), TRAFFIC_SENDER_IDLE, 50, 1'b0, 1'b0);
      run_phase(1, TRAFFIC_RECEIVER_STALL, 40, 1'b0, 1'b0);
      run_phase($urandom_range(31), TRAFFIC_BOTH_IDLE, 70, 1'b0, 1'b0);

      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (expected_settings.size() != 0)
         log_mismatch($sformatf("%0d predicted settings never returned",
            expected_settings.size()));

      $display("Ran %0d point writes and %0d queries (%0d degenerate), %0d results checked,",
               n_writes, n_queries, n_degenerate, n_results);
      $display("over point counts 0, 1, 5, 16 and 31 with steady, idle and stalled traffic.");
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("timeout with %0d settings outstanding", expected_settings.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
sv/dsi_pkg.sv
sv/dsi_ram.sv
sv/dsi_div.sv
sv/dsi_front.sv
sv/dsi_back.sv
sv/daily_schedule_interpolator_core.sv
test/daily_schedule_interpolator_core_tb.sv
